[design/arp_cache_table_top_assert.svh]
// Assertion macros used by the ARP cache table top RTL.
`ifndef ARP_CACHE_TABLE_TOP_ASSERT_SVH
`define ARP_CACHE_TABLE_TOP_ASSERT_SVH

// Clocked check, masked while reset is high.
`define ARPCT_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that is also evaluated during reset.
`define ARPCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/arpct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package arpct_pkg;

   localparam int IP_W  = 32;
   localparam int MAC_W = 48;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_LEARN  = 1'b1;

   localparam logic [1:0] ST_LOOKUP   = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_PRESENT  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic             cmd;
      logic [IP_W-1:0]  ip_addr;
      logic [MAC_W-1:0] hw_addr;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [MAC_W-1:0] mac_out;
      logic [1:0]       status;
   } rsp_type;

   // Search word passed from cell to cell.
   typedef struct packed {
      logic             active;
      logic             cmd;
      logic             found;
      logic             inserted;
      logic [IP_W-1:0]  ip_addr;
      logic [MAC_W-1:0] mac;
   } token_type;

endpackage

`default_nettype wire

[design/arpct_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module arpct_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire arpct_pkg::token_type tok_in,
   output arpct_pkg::token_type      tok_out
);

   logic [arpct_pkg::IP_W-1:0]  entry_ip_ff;
   logic [arpct_pkg::MAC_W-1:0] entry_mac_ff;
   logic                        entry_valid_ff;
   arpct_pkg::token_type        tok_ff;
   arpct_pkg::token_type        tok_in_next;
   logic                        match;
   logic                        store;

   assign match = entry_valid_ff && (entry_ip_ff == tok_in.ip_addr);
   // Valid cells form a prefix, so the first empty cell seen is the next free slot.
   assign store = tok_in.active && (tok_in.cmd == arpct_pkg::CMD_LEARN) &&
                  !tok_in.found && !tok_in.inserted && !entry_valid_ff;

   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.active && !tok_in.found && match) begin
         tok_in_next.found = 1'b1;
         tok_in_next.mac   = entry_mac_ff;
      end
      if (store) begin
         tok_in_next.inserted = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         tok_ff         <= '0;
      end else if (advance) begin
         tok_ff <= tok_in_next;
         if (store) begin
            entry_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && store) begin
         entry_ip_ff  <= tok_in.ip_addr;
         entry_mac_ff <= tok_in.mac;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

[design/arp_cache_table_top.sv]
// ARP cache table: maps a 32-bit IPv4 address to a 48-bit MAC address.
// Input channel req_*: one word per item, cmd selects lookup or learn.
// Output channel rsp_*: exactly one word per item with hit, mac_out, status.
// The table is a chain of ENTRIES cells, each holding one entry. An accepted
// word travels down the chain one cell per cycle while the chain advances;
// each cell compares its entry and the first empty cell takes a learned pair.
// The last cell's word is registered into the output register. One item is
// in the chain at a time, so the block takes no new item until the last one
// has left the chain. Reset empties the table at once (one valid flag per
// cell) and clears both handshakes; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register and the
// chain freezes in place; req_ready stays low while a word is in flight and
// while a finished result waits for rsp_ready.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_cache_table_top_assert.svh"

module arp_cache_table_top #(
   parameter int ENTRIES = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire arpct_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output arpct_pkg::rsp_type      rsp_data
);

   arpct_pkg::token_type tok [0:ENTRIES];
   logic [ENTRIES-1:0]   tok_active;
   logic                 advance;
   logic                 accept;
   logic                 last_active;
   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   arpct_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   assign accept      = req_valid && req_ready;
   // Take a word only when the chain moves, so the first cell latches it.
   assign req_ready   = !busy_ff && advance;
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign last_active = tok[ENTRIES].active;

   always_comb begin
      tok[0]          = '0;
      tok[0].active   = accept;
      tok[0].cmd      = req_data.cmd;
      tok[0].ip_addr  = req_data.ip_addr;
      tok[0].mac      = req_data.hw_addr;
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      arpct_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
      assign tok_active[g] = tok[g+1].active;
   end

   always_comb begin
      rsp_data_in.hit     = tok[ENTRIES].found;
      rsp_data_in.mac_out = tok[ENTRIES].found ? tok[ENTRIES].mac : '0;
      if (tok[ENTRIES].cmd == arpct_pkg::CMD_LOOKUP) begin
         rsp_data_in.status = arpct_pkg::ST_LOOKUP;
      end else if (tok[ENTRIES].found) begin
         rsp_data_in.status = arpct_pkg::ST_PRESENT;
      end else if (tok[ENTRIES].inserted) begin
         rsp_data_in.status = arpct_pkg::ST_INSERTED;
      end else begin
         rsp_data_in.status = arpct_pkg::ST_FULL;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (last_active && advance) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = last_active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_active) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ARPCT_ASSERT_CLK(a_one_word_in_chain, $onehot0(tok_active), "more than one word in the chain")
   `ARPCT_ASSERT_CLK(a_busy_after_accept, accept |=> busy_ff, "accept did not mark busy")
   `ARPCT_ASSERT_CLK(a_idle_chain_empty, !busy_ff |-> (tok_active == '0),
                     "word in chain while idle")
   `ARPCT_ASSERT_CLK(a_present_hits,
                     rsp_valid && (rsp_data.status == arpct_pkg::ST_PRESENT) |-> rsp_data.hit,
                     "present status without hit")
   `ARPCT_ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> !rsp_valid_ff && !busy_ff,
                        "reset left handshake state set")

endmodule

`default_nettype wire

[dv/arp_cache_table_checker.sv]
`timescale 1ns / 1ps

module arp_cache_table_checker #(
   parameter int ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  arpct_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  arpct_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending,
   output int                 seen_hits,
   output int                 seen_inserts,
   output int                 seen_repeats,
   output int                 seen_drops
);

   logic [arpct_pkg::IP_W-1:0]  cache_ip   [ENTRIES];
   logic [arpct_pkg::MAC_W-1:0] cache_mac  [ENTRIES];
   logic                        cache_used [ENTRIES];
   int                          cache_fill;

   arpct_pkg::rsp_type answers_due[$];
   arpct_pkg::rsp_type want;
   int                 errs;
   int                 hits, inserts, repeats, drops;

   // Search the used slots from the bottom, then apply a learn.
   function automatic arpct_pkg::rsp_type resolve_arp(input arpct_pkg::req_type w);
      arpct_pkg::rsp_type r;
      int                 slot;
      r    = '0;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot < 0 && cache_used[i] && cache_ip[i] == w.ip_addr) slot = i;
      end
      if (slot >= 0) begin
         r.hit     = 1'b1;
         r.mac_out = cache_mac[slot];
      end
      if (w.cmd == arpct_pkg::CMD_LOOKUP) begin
         r.status = arpct_pkg::ST_LOOKUP;
      end else if (slot >= 0) begin
         r.status = arpct_pkg::ST_PRESENT;
      end else if (cache_fill >= ENTRIES) begin
         r.status = arpct_pkg::ST_FULL;
      end else begin
         cache_ip[cache_fill]   = w.ip_addr;
         cache_mac[cache_fill]  = w.hw_addr;
         cache_used[cache_fill] = 1'b1;
         cache_fill++;
         r.status = arpct_pkg::ST_INSERTED;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) cache_used[i] = 1'b0;
         cache_fill = 0;
         answers_due.delete();
      end else begin
         if (req_valid && req_ready) answers_due.push_back(resolve_arp(req_data));
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("unexpected response word: hit %0b mac %012h status %0d",
                      rsp_data.hit, rsp_data.mac_out, rsp_data.status);
               errs++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_data.hit !== want.hit) begin
                  $error("hit: expected %0b, got %0b", want.hit, rsp_data.hit);
                  errs++;
               end
               if (rsp_data.mac_out !== want.mac_out) begin
                  $error("mac_out: expected %012h, got %012h",
                         want.mac_out, rsp_data.mac_out);
                  errs++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errs++;
               end
               if (want.hit) hits++;
               case (want.status)
                  arpct_pkg::ST_INSERTED: inserts++;
                  arpct_pkg::ST_PRESENT:  repeats++;
                  arpct_pkg::ST_FULL:     drops++;
                  default: ;
               endcase
            end
         end
      end
      fail_count   <= errs;
      pending      <= answers_due.size();
      seen_hits    <= hits;
      seen_inserts <= inserts;
      seen_repeats <= repeats;
      seen_drops   <= drops;
   end

endmodule

[dv/arp_cache_table_top_tb.sv]
`timescale 1ns / 1ps

module arp_cache_table_top_tb;

   localparam int ENTRIES     = 16;
   localparam int RANDOM_ITEMS = 600;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   arpct_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   arpct_pkg::rsp_type rsp_data;

   int   fail_count, pending;
   int   seen_hits, seen_inserts, seen_repeats, seen_drops;
   int   cycles    = 0;
   int   hold_left = 0;
   logic hold_ask   = 1'b0;
   logic hold_taken = 1'b0;
   logic calm       = 1'b0;
   int   words_sent = 0;

   logic [arpct_pkg::IP_W-1:0] known_ips[$];

   always #4 clock = ~clock;

   arp_cache_table_top #(.ENTRIES(ENTRIES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   arp_cache_table_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .seen_hits    (seen_hits),
      .seen_inserts (seen_inserts),
      .seen_repeats (seen_repeats),
      .seen_drops   (seen_drops)
   );

   // Receiver: random stalls, one long hold-off on request, none while calm.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_ask && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("arp_cache_table_top_tb: done, errors");
         $finish;
      end
   end

   function automatic arpct_pkg::req_type make_word(input logic cmd,
                                                    input logic [arpct_pkg::IP_W-1:0] ip,
                                                    input logic [arpct_pkg::MAC_W-1:0] mac);
      arpct_pkg::req_type w;
      w.cmd     = cmd;
      w.ip_addr = ip;
      w.hw_addr = mac;
      return w;
   endfunction

   // Mix fresh addresses, learned ones and one-bit neighbors of learned ones.
   function automatic arpct_pkg::req_type random_word();
      arpct_pkg::req_type         w;
      logic [63:0]                r;
      int                         pick;
      logic [arpct_pkg::IP_W-1:0] ip;
      r    = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      w.cmd     = ($urandom_range(99) < 40) ? arpct_pkg::CMD_LEARN : arpct_pkg::CMD_LOOKUP;
      w.hw_addr = r[arpct_pkg::MAC_W-1:0];
      if (known_ips.size() == 0 || pick < 25) begin
         ip = $urandom();
         if (w.cmd == arpct_pkg::CMD_LEARN) known_ips.push_back(ip);
      end else if (pick < 85) begin
         ip = known_ips[$urandom_range(known_ips.size() - 1)];
      end else begin
         ip = known_ips[$urandom_range(known_ips.size() - 1)] ^
              (32'd1 << $urandom_range(31));
      end
      w.ip_addr = ip;
      return w;
   endfunction

   // Hold the word until accepted.
   task automatic send_word(input arpct_pkg::req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      arpct_pkg::req_type directed[$];

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, address extremes, repeats that keep the first MAC, neighbors
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'h0000_0000, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      directed.push_back(make_word(arpct_pkg::CMD_LEARN,  32'h0000_0000, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LEARN,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      directed.push_back(make_word(arpct_pkg::CMD_LEARN,  32'h0000_0000, 48'hFFFF_FFFF_FFFF));
      directed.push_back(make_word(arpct_pkg::CMD_LEARN,  32'hFFFF_FFFF, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'h0000_0000, 48'hA5A5_A5A5_A5A5));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'h0000_0001, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'h8000_0000, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LEARN,  32'hC0A8_0001, 48'h0200_0000_0001));
      directed.push_back(make_word(arpct_pkg::CMD_LEARN,  32'h8000_0000, 48'h8000_0000_0000));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'hC0A8_0001, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'h8000_0000, 48'h0));
      directed.push_back(make_word(arpct_pkg::CMD_LOOKUP, 32'hC0A8_0101, 48'h0));
      foreach (directed[i]) begin
         if (directed[i].cmd == arpct_pkg::CMD_LEARN) known_ips.push_back(directed[i].ip_addr);
         send_word(directed[i]);
      end
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) hold_ask <= 1'b1;
         if (n == 300) drain();
         if (n == 400) calm <= 1'b1;
         if (n == 480) calm <= 1'b0;
         if (!calm && n != 300 && $urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
         send_word(random_word());
      end
      drain();
      repeat (ENTRIES + 8) @(posedge clock);

      $display("sent %0d words over %0d cycles; table filled to %0d of %0d slots",
               words_sent, cycles, seen_inserts, ENTRIES);
      $display("responses: %0d hits, %0d repeat learns, %0d learns dropped on a full table",
               seen_hits, seen_repeats, seen_drops);
      if (fail_count == 0) begin
         $display("arp_cache_table_top_tb: done, clean");
      end else begin
         $display("arp_cache_table_top_tb: done, errors");
      end
      $finish;
   end

endmodule
